/* src/pfrm_pkg.sv */
// ----------------------------------------------------------------------------
// pfrm_pkg
// Shared types and constants for the first-match packet filter.
// ----------------------------------------------------------------------------
package pfrm_pkg;

    // Default number of rule slots in the table.
    localparam int RULE_SLOTS_DEF = 256;

    // Request operation codes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Result codes.
    localparam logic VERDICT_DENY  = 1'b0;
    localparam logic VERDICT_ALLOW = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One stored rule. A zero in an address, port or protocol field is a wildcard.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
        logic        dir;
        logic        act;
    } rule_t;

    // Packet fields that a check compares against each rule.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
        logic        dir;
    } pkt_key_t;

    // Outcome of comparing one rule against the packet.
    typedef struct packed {
        logic hit;
        logic act;
    } match_t;

endpackage

/* src/pfrm_rule_mem.sv */
// ----------------------------------------------------------------------------
// pfrm_rule_mem
// Rule table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfrm_rule_mem #(
    parameter int DEPTH  = pfrm_pkg::RULE_SLOTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pfrm_pkg::rule_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pfrm_pkg::rule_t     rd_data
);
    import pfrm_pkg::*;

    rule_t mem [DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pfrm_match.sv */
// ----------------------------------------------------------------------------
// pfrm_match
// Compares one stored rule against the packet key, honoring wildcard fields.
// ----------------------------------------------------------------------------
module pfrm_match (
    input  pfrm_pkg::rule_t    rule,
    input  pfrm_pkg::pkt_key_t key,
    output pfrm_pkg::match_t   result
);
    import pfrm_pkg::*;

    logic src_addr_ok;
    logic dst_addr_ok;
    logic src_port_ok;
    logic dst_port_ok;
    logic proto_ok;
    logic dir_ok;

    always_comb begin
        src_addr_ok = (rule.src_addr == 32'd0) || (rule.src_addr == key.src_addr);
        dst_addr_ok = (rule.dst_addr == 32'd0) || (rule.dst_addr == key.dst_addr);
        src_port_ok = (rule.src_port == 16'd0) || (rule.src_port == key.src_port);
        dst_port_ok = (rule.dst_port == 16'd0) || (rule.dst_port == key.dst_port);
        proto_ok    = (rule.proto == 8'd0) || (rule.proto == key.proto);
        dir_ok      = (rule.dir == key.dir);
        result.hit  = dir_ok && src_addr_ok && dst_addr_ok && src_port_ok &&
                      dst_port_ok && proto_ok;
        result.act  = rule.act;
    end

endmodule

/* src/packet_filter_rule_match.sv */
// ----------------------------------------------------------------------------
// packet_filter_rule_match
// First-match five-tuple packet filter over a rule table held in one memory.
// ----------------------------------------------------------------------------
// Answers: an add request is answered through ST_DONE and the output register.
// A check reads the stored rules in order from slot 0 and is answered once the
// first hit is found or every stored rule has missed (at once on an empty table).
// Only one request is handled at a time; a check's scan is paced by the single
// read port of the rule memory, so it grows with the number of stored rules.
// Reset (aresetn low, synchronous) empties the table by clearing the rule count;
// the memory itself is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module packet_filter_rule_match #(
    parameter int RULE_SLOTS = pfrm_pkg::RULE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_source_addr,
    input  logic [31:0] s_dest_addr,
    input  logic [15:0] s_source_port_num,
    input  logic [15:0] s_dest_port_num,
    input  logic [7:0]  s_proto_num,
    input  logic        s_rule_action,
    input  logic        s_traffic_dir,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_verdict,
    output logic        m_status
);
    import pfrm_pkg::*;

    // Address width of the table and width of a count that can reach RULE_SLOTS.
    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(RULE_SLOTS);

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    pkt_key_t        key_reg, key_next;
    logic            res_verdict_reg, res_verdict_next;
    logic            res_status_reg, res_status_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_verdict_reg, m_verdict_next;
    logic            m_status_reg, m_status_next;

    logic            accept;
    logic            table_full;
    logic            out_free;
    logic            wr_en;
    logic            rd_en;
    rule_t           wr_rule;
    rule_t           rd_rule;
    match_t          match;

    // A request is taken only while idle; a result waiting in the output
    // register does not hold off the next request.
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign table_full = (count_reg == SLOTS_CNT);
    assign out_free   = !m_valid_reg || m_ready;

    // An add that finds the table not full writes the new rule at the next free slot in the cycle it is taken.
    assign wr_en = accept && (s_op == OP_ADD) && !table_full;

    always_comb begin
        wr_rule.src_addr = s_source_addr;
        wr_rule.dst_addr = s_dest_addr;
        wr_rule.src_port = s_source_port_num;
        wr_rule.dst_port = s_dest_port_num;
        wr_rule.proto    = s_proto_num;
        wr_rule.dir      = s_traffic_dir;
        wr_rule.act      = s_rule_action;
    end

    // The scan issues one read per cycle while stored rules remain and stops
    // issuing as soon as the rule whose data is back hits.
    assign rd_en = (state_reg == ST_SCAN) && (idx_reg < count_reg) &&
                   !(pend_reg && match.hit);

    pfrm_rule_mem #(
        .DEPTH  (RULE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_rule_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_rule)
    );

    pfrm_match u_match (
        .rule   (rd_rule),
        .key    (key_reg),
        .result (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        key_reg         <= key_next;
        res_verdict_reg <= res_verdict_next;
        res_status_reg  <= res_status_next;
        m_verdict_reg   <= m_verdict_next;
        m_status_reg    <= m_status_next;
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        key_next         = key_reg;
        res_verdict_next = res_verdict_reg;
        res_status_next  = res_status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next.src_addr = s_source_addr;
                    key_next.dst_addr = s_dest_addr;
                    key_next.src_port = s_source_port_num;
                    key_next.dst_port = s_dest_port_num;
                    key_next.proto    = s_proto_num;
                    key_next.dir      = s_traffic_dir;
                    if (s_op == OP_ADD) begin
                        res_verdict_next = VERDICT_DENY;
                        res_status_next  = table_full ? STATUS_FULL : STATUS_OK;
                        if (!table_full) begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg && match.hit) begin
                    // First matching rule decides.
                    res_verdict_next = match.act;
                    res_status_next  = STATUS_OK;
                    pend_next        = 1'b0;
                    state_next       = ST_DONE;
                end else if (rd_en) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    // Every stored rule missed: the default is allow.
                    res_verdict_next = VERDICT_ALLOW;
                    res_status_next  = STATUS_OK;
                    state_next       = ST_DONE;
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded when a result is ready and the slot is free.
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_verdict_next = m_verdict_reg;
        m_status_next  = m_status_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next   = 1'b1;
            m_verdict_next = res_verdict_reg;
            m_status_next  = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;
    assign m_status  = m_status_reg;

`ifndef ASSERT_OFF
    // The rule count never runs past the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_CNT)
        else $error("rule count exceeds table size");

    // An add refused for a full table leaves the count unchanged.
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == OP_ADD) && table_full) |=> (count_reg == $past(count_reg)))
        else $error("full table changed on refused add");

    // A table-full answer always carries a deny verdict.
    a_full_deny: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STATUS_FULL)) |-> (m_verdict_reg == VERDICT_DENY))
        else $error("table full result with allow verdict");

    // Read data is only awaited during a scan.
    a_pend_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("pending read outside of a scan");
`endif

endmodule
